// ===== src/xxhash64_stream_defines.svh =====
// Assertion macros for the XXH64 stream hasher.
`ifndef XXHASH64_STREAM_DEFINES_SVH
`define XXHASH64_STREAM_DEFINES_SVH

`define XXH_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("xxh64 assertion failed");

`define XXH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("xxh64 assertion failed");

`endif

// ===== src/xxh_pkg.sv =====
// Types, constants and helpers shared by the XXH64 stream hasher.
package xxh_pkg;

  localparam logic [63:0] P1 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] P2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] P3 = 64'h165667B19E3779F9;
  localparam logic [63:0] P4 = 64'h85EBCA77C2B2AE63;
  localparam logic [63:0] P5 = 64'h27D4EB2F165667C5;

  localparam logic [3:0] FULL_WORD = 4'd8;
  localparam logic [3:0] HALF_WORD = 4'd4;
  localparam logic [1:0] STRIPE_HELD = 2'd3;
  localparam logic [1:0] QUEUE_DEPTH = 2'd2;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
  } xxh_item_t;

  typedef struct packed {
    logic [1:0] count;
  } xxh_front_status_t;

  typedef struct packed {
    logic emit;
  } xxh_back_status_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LR1, ST_LR2, ST_FIN, ST_MG1, ST_MG2, ST_MG3, ST_LEN, ST_TW,
    ST_F1, ST_F2, ST_F3, ST_Q1, ST_Q2, ST_B0, ST_B1, ST_B2, ST_AV1, ST_AV2,
    ST_OUT
  } xxh_state_t;

  function automatic logic [63:0] rotl(input logic [63:0] v, input int unsigned n);
    return (v << n) | (v >> (64 - n));
  endfunction

endpackage

// ===== src/xxh_if.sv =====
// Valid/ready channel interfaces for words in and hashes out.
interface xxh_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  valid_bytes;
  logic        last;
  modport source(output valid, data_word, valid_bytes, last, input ready);
  modport sink(input valid, data_word, valid_bytes, last, output ready);
endinterface

interface xxh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;
  modport source(output valid, hash_value, input ready);
  modport sink(input valid, hash_value, output ready);
endinterface

// ===== src/xxh_front.sv =====
// Input stage: classify words and queue them for the hash engine.
module xxh_front
  import xxh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  xxh_in_if.sink            in_ch,
  output xxh_item_t         q_item,
  output logic              q_valid,
  input  logic              q_pop,
  output xxh_front_status_t status
);

  xxh_item_t  entries [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  xxh_item_t  item_in;

  always_comb begin
    item_in.word   = in_ch.data_word;
    item_in.last   = in_ch.last;
    item_in.nbytes = (!in_ch.last || in_ch.valid_bytes > FULL_WORD) ? FULL_WORD
                                                                  : in_ch.valid_bytes;
  end

  assign in_ch.ready  = (count != QUEUE_DEPTH);
  assign push         = in_ch.valid && in_ch.ready;
  assign q_valid      = (count != 2'd0);
  assign q_item       = entries[rptr];
  assign status.count = count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= item_in;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (q_pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ===== src/xxh_mul.sv =====
// Two-stage 64-bit low-half multiplier built from 32-bit partial products.
module xxh_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] p
);

  logic [63:0] ll;
  logic [63:0] lh;
  logic [63:0] hl;
  logic [63:0] p0;
  logic [31:0] p1;
  logic [31:0] p2;
  logic        s1_valid;

  always_comb begin
    ll = a[31:0] * b[31:0];
    lh = a[31:0] * b[63:32];
    hl = a[63:32] * b[31:0];
  end

  always_ff @(posedge clk) begin
    p0 <= ll;
    p1 <= lh[31:0];
    p2 <= hl[31:0];
    p  <= p0 + {p1 + p2, 32'b0};
    if (rst) begin
      s1_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= start;
      done     <= s1_valid;
    end
  end

endmodule

// ===== src/xxh_back.sv =====
// Hash engine: stripe rounds, merge, tail fold and avalanche on one multiplier.
module xxh_back
  import xxh_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [63:0]      seed,
  input  xxh_item_t        q_item,
  input  logic             q_valid,
  output logic             q_pop,
  xxh_out_if.source        out_ch,
  output xxh_back_status_t status
);

  xxh_state_t  state;
  xxh_state_t  state_next;
  logic [63:0] acc [4];
  logic [63:0] held [3];
  logic [1:0]  hcnt;
  logic [63:0] mlen;
  logic        seen;
  logic [63:0] h;
  logic [63:0] tmp;
  logic [63:0] fw;
  logic [63:0] cur_word;
  logic [3:0]  cur_n;
  logic        cur_last;
  logic [1:0]  lane;
  logic [1:0]  idx;
  logic [3:0]  pos;
  logic        used;
  logic        pend;
  logic        ovalid;
  logic [63:0] ohash;

  logic        mul_state;
  logic        mul_start;
  logic [63:0] mul_a;
  logic [63:0] mul_b;
  logic        mul_done;
  logic [63:0] mul_p;
  logic        fold_now;
  logic        can_load;
  logic [63:0] merge;

  xxh_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  assign fold_now      = (q_item.nbytes == FULL_WORD) && (hcnt == STRIPE_HELD);
  assign can_load      = !ovalid || out_ch.ready;
  assign out_ch.valid  = ovalid;
  assign out_ch.hash_value = ohash;
  assign status.emit   = (state == ST_OUT);
  assign merge = rotl(acc[0], 1) + rotl(acc[1], 7) + rotl(acc[2], 12) + rotl(acc[3], 18);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          if (fold_now) state_next = ST_LR1;
          else if (q_item.last) state_next = ST_FIN;
        end
      end
      ST_LR1: if (mul_done) state_next = ST_LR2;
      ST_LR2: begin
        if (mul_done) begin
          if (lane != 2'd3) state_next = ST_LR1;
          else if (cur_last) state_next = ST_FIN;
          else state_next = ST_IDLE;
        end
      end
      ST_FIN: state_next = seen ? ST_MG1 : ST_LEN;
      ST_MG1: if (mul_done) state_next = ST_MG2;
      ST_MG2: if (mul_done) state_next = ST_MG3;
      ST_MG3: if (mul_done) state_next = (lane == 2'd3) ? ST_LEN : ST_MG1;
      ST_LEN: state_next = ST_TW;
      ST_TW: begin
        if (idx < hcnt) state_next = ST_F1;
        else if (!used) begin
          if (cur_n == FULL_WORD) state_next = ST_F1;
          else if (cur_n >= HALF_WORD) state_next = ST_Q1;
          else state_next = ST_B0;
        end else state_next = ST_B0;
      end
      ST_F1: if (mul_done) state_next = ST_F2;
      ST_F2: if (mul_done) state_next = ST_F3;
      ST_F3: if (mul_done) state_next = ST_TW;
      ST_Q1: if (mul_done) state_next = ST_Q2;
      ST_Q2: if (mul_done) state_next = ST_B0;
      ST_B0: state_next = (pos < cur_n) ? ST_B1 : ST_AV1;
      ST_B1: if (mul_done) state_next = ST_B2;
      ST_B2: if (mul_done) state_next = ST_B0;
      ST_AV1: if (mul_done) state_next = ST_AV2;
      ST_AV2: if (mul_done) state_next = ST_OUT;
      ST_OUT: if (can_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_state = 1'b1;
    mul_a     = h;
    mul_b     = P1;
    q_pop     = (state == ST_IDLE) && q_valid;
    unique case (state)
      ST_LR1: begin
        mul_a = (lane == 2'd3) ? cur_word : held[lane];
        mul_b = P2;
      end
      ST_LR2, ST_MG2, ST_F2: mul_a = tmp;
      ST_MG1: begin
        mul_a = acc[lane];
        mul_b = P2;
      end
      ST_MG3: mul_a = h;
      ST_F1: begin
        mul_a = fw;
        mul_b = P2;
      end
      ST_F3: mul_a = rotl(h, 27);
      ST_Q1: mul_a = {32'b0, cur_word[31:0]};
      ST_Q2: begin
        mul_a = rotl(h, 23);
        mul_b = P2;
      end
      ST_B1: begin
        mul_a = {56'b0, cur_word[{pos[2:0], 3'b000} +: 8]};
        mul_b = P5;
      end
      ST_B2: mul_a = rotl(h, 11);
      ST_AV1: begin
        mul_a = h ^ (h >> 33);
        mul_b = P2;
      end
      ST_AV2: begin
        mul_a = h ^ (h >> 29);
        mul_b = P3;
      end
      default: mul_state = 1'b0;
    endcase
    mul_start = mul_state && !pend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      pend   <= 1'b0;
      hcnt   <= 2'd0;
      mlen   <= 64'd0;
      seen   <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      if (mul_start) pend <= 1'b1;
      else if (mul_done) pend <= 1'b0;
      if (state == ST_OUT && can_load) ovalid <= 1'b1;
      else if (out_ch.ready) ovalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cur_word <= q_item.word;
            cur_n    <= q_item.nbytes;
            cur_last <= q_item.last;
            pos      <= q_item.nbytes;
            mlen     <= mlen + {60'b0, q_item.nbytes};
            used     <= fold_now;
            if (fold_now) begin
              lane <= 2'd0;
              if (!seen) begin
                acc[0] <= seed + P1 + P2;
                acc[1] <= seed + P2;
                acc[2] <= seed;
                acc[3] <= seed - P1;
              end
            end else if (q_item.nbytes == FULL_WORD && !q_item.last) begin
              held[hcnt] <= q_item.word;
              hcnt       <= hcnt + 2'd1;
            end
          end
        end
        ST_LR1: if (mul_done) tmp <= rotl(acc[lane] + mul_p, 31);
        ST_LR2: begin
          if (mul_done) begin
            acc[lane] <= mul_p;
            lane      <= lane + 2'd1;
            if (lane == 2'd3) begin
              seen <= 1'b1;
              hcnt <= 2'd0;
            end
          end
        end
        ST_FIN: begin
          lane <= 2'd0;
          h    <= seen ? merge : seed + P5;
        end
        ST_MG1, ST_F1: if (mul_done) tmp <= rotl(mul_p, 31);
        ST_MG2, ST_F2, ST_Q1, ST_B1: if (mul_done) h <= h ^ mul_p;
        ST_MG3: begin
          if (mul_done) begin
            h    <= mul_p + P4;
            lane <= lane + 2'd1;
          end
        end
        ST_LEN: begin
          h   <= h + mlen;
          idx <= 2'd0;
        end
        ST_TW: begin
          if (idx < hcnt) begin
            fw  <= held[idx];
            idx <= idx + 2'd1;
          end else if (!used) begin
            used <= 1'b1;
            fw   <= cur_word;
            if (cur_n == FULL_WORD) pos <= FULL_WORD;
            else if (cur_n >= HALF_WORD) pos <= HALF_WORD;
            else pos <= 4'd0;
          end
        end
        ST_F3: if (mul_done) h <= mul_p + P4;
        ST_Q2: if (mul_done) h <= mul_p + P3;
        ST_B2: begin
          if (mul_done) begin
            h   <= mul_p;
            pos <= pos + 4'd1;
          end
        end
        ST_AV1: if (mul_done) h <= mul_p;
        ST_AV2: if (mul_done) h <= mul_p ^ (mul_p >> 32);
        ST_OUT: begin
          if (can_load) begin
            ohash  <= h;
            hcnt   <= 2'd0;
            mlen   <= 64'd0;
            seen   <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== src/xxhash64_stream.sv =====
// Work: a held word is only stored; a completed stripe runs eight multiplies on the one
// shared two-stage multiplier; a last word adds merge, tail fold and avalanche on the
// same multiplier.
// A 2-entry queue buffers input; the engine pops a new word only when idle.
// Reset: synchronous, active high; seed clears to zero, queue and message state empty.
// Top level of the streaming XXH64 hasher.
`include "xxhash64_stream_defines.svh"
module xxhash64_stream
  import xxh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  xxh_in_if.sink      in_ch,
  xxh_out_if.source   out_ch
);

  logic [63:0]       seed;
  xxh_item_t         q_item;
  logic              q_valid;
  logic              q_pop;
  xxh_front_status_t fst;
  xxh_back_status_t  bst;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= 64'd0;
    end else if (cfg_we) begin
      seed <= cfg_wdata;
    end
  end

  xxh_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .status  (fst)
  );

  xxh_back u_back (
    .clk     (clk),
    .rst     (rst),
    .seed    (seed),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .out_ch  (out_ch),
    .status  (bst)
  );

  `XXH_ASSERT_NOW(a_queue_depth, 1'b1, fst.count <= QUEUE_DEPTH)
  `XXH_ASSERT_NOW(a_stall_full, !in_ch.ready, fst.count == QUEUE_DEPTH)
  `XXH_ASSERT_NOW(a_emit_source, $rose(out_ch.valid), $past(bst.emit))
  `XXH_ASSERT_NEXT(a_pop_count, q_pop && !(in_ch.valid && in_ch.ready),
                   fst.count == $past(fst.count) - 2'd1)

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the streaming XXH64 hasher.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import xxh_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
    bit          known;
    logic [63:0] hash;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [63:0] cfg_wdata = '0;

  xxh_in_if  in_ch();
  xxh_out_if out_ch();

  xxhash64_stream i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [63:0] pr_seed;
  logic [63:0] pr_lane [4];
  logic [63:0] pr_held [3];
  int unsigned pr_count;
  logic [63:0] pr_len;
  bit          pr_striped;

  logic [63:0] hash_queue [$];
  int unsigned errors = 0;
  int unsigned hashes_seen = 0;
  int unsigned words_sent = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  function automatic logic [63:0] rol(input logic [63:0] v, input int unsigned n);
    return (v << n) | (v >> (64 - n));
  endfunction

  function automatic logic [63:0] lane_mix(input logic [63:0] a, input logic [63:0] w);
    logic [63:0] t;
    t = a + w * P2;
    return rol(t, 31) * P1;
  endfunction

  function automatic logic [63:0] tail_word(input logic [63:0] h, input logic [63:0] w);
    logic [63:0] t;
    t = h ^ lane_mix(64'd0, w);
    return rol(t, 27) * P1 + P4;
  endfunction

  function automatic void seed_lanes();
    pr_lane[0] = pr_seed + P1 + P2;
    pr_lane[1] = pr_seed + P2;
    pr_lane[2] = pr_seed;
    pr_lane[3] = pr_seed - P1;
  endfunction

  function automatic void hash_reset();
    pr_seed = '0;
    seed_lanes();
    pr_count = 0;
    pr_len = '0;
    pr_striped = 0;
  endfunction

  // returns 1 and the hash when the word closes a message
  function automatic bit hash_word(input logic [63:0] w, input logic [3:0] nb,
                                   input logic lst, output logic [63:0] h);
    int unsigned n;
    int unsigned p;
    bit used;
    used = 0;
    n = nb;
    if (!lst || n > 8) n = 8;
    pr_len += n;
    if (n == 8) begin
      if (pr_count == 3) begin
        if (!pr_striped) seed_lanes();
        pr_lane[0] = lane_mix(pr_lane[0], pr_held[0]);
        pr_lane[1] = lane_mix(pr_lane[1], pr_held[1]);
        pr_lane[2] = lane_mix(pr_lane[2], pr_held[2]);
        pr_lane[3] = lane_mix(pr_lane[3], w);
        pr_striped = 1;
        pr_count = 0;
        used = 1;
      end else if (!lst) begin
        pr_held[pr_count] = w;
        pr_count++;
        used = 1;
      end
    end
    h = '0;
    if (!lst) return 0;
    if (pr_striped) begin
      h = rol(pr_lane[0], 1) + rol(pr_lane[1], 7) + rol(pr_lane[2], 12) +
          rol(pr_lane[3], 18);
      for (int i = 0; i < 4; i++) begin
        h ^= lane_mix(64'd0, pr_lane[i]);
        h = h * P1 + P4;
      end
    end else begin
      h = pr_seed + P5;
    end
    h += pr_len;
    for (int i = 0; i < pr_count; i++) h = tail_word(h, pr_held[i]);
    if (!used) begin
      p = 0;
      if (n == 8) begin
        h = tail_word(h, w);
        p = 8;
      end else if (n >= 4) begin
        h ^= {32'd0, w[31:0]} * P1;
        h = rol(h, 23) * P2 + P3;
        p = 4;
      end
      for (; p < n; p++) begin
        h ^= {56'd0, w[8*p +: 8]} * P5;
        h = rol(h, 11) * P1;
      end
    end
    h ^= h >> 33;
    h *= P2;
    h ^= h >> 29;
    h *= P3;
    h ^= h >> 32;
    seed_lanes();
    pr_count = 0;
    pr_len = '0;
    pr_striped = 0;
    return 1;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic set_seed(input logic [63:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    pr_seed = v;
  endtask

  // drain outstanding hashes, then let the block settle
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (hash_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic send_word(input logic [63:0] w, input logic [3:0] nb, input logic lst);
    logic [63:0] h;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_word <= w;
    in_ch.valid_bytes <= nb;
    in_ch.last <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
    if (hash_word(w, nb, lst, h)) hash_queue.push_back(h);
  endtask

  task automatic send_message(input int unsigned nwords);
    logic [3:0] nb;
    for (int i = 0; i < nwords; i++) begin
      if (i == nwords - 1) nb = 4'($urandom_range(15));
      else if ($urandom_range(9) == 0) nb = 4'($urandom_range(15));
      else nb = 4'd8;
      send_word(rand64(), nb, i == nwords - 1);
    end
  endtask

  // hash sink and checker
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (hash_queue.size() == 0) begin
          $error("unexpected hash_value %h", out_ch.hash_value);
          errors++;
        end else begin
          if (out_ch.hash_value !== hash_queue[0]) begin
            $error("hash_value expected %h actual %h", hash_queue[0], out_ch.hash_value);
            errors++;
          end
          void'(hash_queue.pop_front());
        end
        hashes_seen++;
      end
      out_ch.ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  stim_row_t rows [$];

  initial begin
    stim_row_t r;
    logic [63:0] h;
    in_ch.valid = 1'b0;
    in_ch.data_word = '0;
    in_ch.valid_bytes = '0;
    in_ch.last = 1'b0;
    hash_reset();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty message with zero seed: well-known XXH64 of nothing
    rows.push_back('{64'h0, 4'd0, 1'b1, 1, 64'hEF46DB3751D8E999});
    rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 0, '0});
    rows.push_back('{64'h0, 4'd15, 1'b1, 0, '0});
    rows.push_back('{64'h0706050403020100, 4'd3, 1'b1, 0, '0});
    rows.push_back('{64'h0706050403020100, 4'd4, 1'b1, 0, '0});
    rows.push_back('{64'hDEADBEEFCAFEF00D, 4'd7, 1'b1, 0, '0});
    rows.push_back('{64'h1111111111111111, 4'd2, 1'b0, 0, '0});
    rows.push_back('{64'h2222222222222222, 4'd1, 1'b1, 0, '0});
    for (int i = 0; i < 4; i++)
      rows.push_back('{{16{4'(i + 1)}}, 4'd8, i == 3, 0, '0});
    for (int i = 0; i < 5; i++)
      rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0, 0, '0});
    rows.push_back('{64'h0, 4'd5, 1'b1, 0, '0});
    for (int i = 0; i < 7; i++)
      rows.push_back('{64'h0123456789ABCDEF ^ 64'(i), 4'd8, 1'b0, 0, '0});
    rows.push_back('{64'h8000000000000001, 4'd0, 1'b1, 0, '0});

    foreach (rows[k]) begin
      r = rows[k];
      if (r.known) begin
        void'(hash_word(r.word, r.nbytes, r.last, h));
        hash_queue.push_back(r.hash);
        in_ch.valid <= 1'b1;
        in_ch.data_word <= r.word;
        in_ch.valid_bytes <= r.nbytes;
        in_ch.last <= r.last;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        words_sent++;
      end else begin
        send_word(r.word, r.nbytes, r.last);
      end
    end
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_seed(64'hFFFF_FFFF_FFFF_FFFF);
        1: set_seed(64'h0);
        default: set_seed(rand64());
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      for (int m = 0; m < 13; m++) begin
        if ($urandom_range(9) == 0) send_message($urandom_range(20, 40));
        else send_message($urandom_range(1, 9));
        // hold until every hash is back now and then
        if (m == 10) begin
          in_ch.valid <= 1'b0;
          while (hash_queue.size() != 0) @(posedge clk);
        end
      end
      wait_drained();
    end

    $display("Sent %0d words and checked %0d hashes over six seed settings.",
             words_sent, hashes_seen);
    if (errors == 0 && hash_queue.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/xxh_pkg.sv
src/xxh_if.sv
src/xxh_front.sv
src/xxh_mul.sv
src/xxh_back.sv
src/xxhash64_stream.sv
tb/sv/testbench.sv
